/* rtl/core/radix_number_literal_parser_assert.svh */
// assertion macros for the rtl of the literal parser
`ifndef RADIX_NUMBER_LITERAL_PARSER_ASSERT_SVH
`define RADIX_NUMBER_LITERAL_PARSER_ASSERT_SVH

`ifndef SYNTHESIS

// checked property, off while reset is held
`define RNLP_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// checked property that also holds during reset
`define RNLP_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define RNLP_ASSERT(name, clk, rst_n, prop, msg)
`define RNLP_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

/* rtl/core/rnlp_pkg.sv */
package rnlp_pkg;

  localparam int DEF_INT_BITS  = 32;
  localparam int DEF_FRAC_BITS = 32;

  localparam logic [7:0] CH_ZERO = 8'h30;  // '0'
  localparam logic [7:0] CH_ONE  = 8'h31;  // '1'
  localparam logic [7:0] CH_NINE = 8'h39;  // '9'
  localparam logic [7:0] CH_A_LC = 8'h61;  // 'a'
  localparam logic [7:0] CH_B_LC = 8'h62;  // 'b'
  localparam logic [7:0] CH_F_LC = 8'h66;  // 'f'
  localparam logic [7:0] CH_X_LC = 8'h78;  // 'x'
  localparam logic [7:0] CH_DOT  = 8'h2e;  // '.'

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_ZERO  = 2'd1,
    PH_BODY  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_BIN = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_SATURATED = 2'd2
  } status_t;

  // one character item as held in the input register
  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } char_item_t;

endpackage

/* rtl/core/rnlp_in_reg.sv */
module rnlp_in_reg
  import rnlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  char_item_t in_item,
  input  logic       advance,
  output logic       item_valid,
  output char_item_t item
);

  logic       valid_r;
  char_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

/* rtl/core/rnlp_parse_core.sv */
module rnlp_parse_core
  import rnlp_pkg::*;
#(
  parameter int INT_BITS  = DEF_INT_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  char_item_t                    item,
  output logic                          res_valid,
  output logic [INT_BITS+FRAC_BITS-1:0] res_value,
  output status_t                       res_status
);

  localparam int IW = INT_BITS;
  localparam int FW = FRAC_BITS;

  // reciprocal for an exact floor divide by ten of any FW-bit value
  localparam logic [63:0] DIV10_M64  = ((64'd1 << (FW + 3)) + 64'd9) / 64'd10;
  localparam logic [FW-1:0] DIV10_M  = DIV10_M64[FW-1:0];
  localparam logic [63:0] SCALE10_64 = (64'd1 << FW) / 64'd10;
  localparam logic [FW-1:0] SCALE10  = SCALE10_64[FW-1:0];
  localparam logic [FW-1:0] SCALE2   = FW'(1) << (FW - 1);
  localparam logic [FW-1:0] SCALE16  = FW'(1) << (FW - 4);
  localparam logic [IW-1:0] INT_MAX  = '1;
  localparam logic [FW-1:0] FRAC_MAX = '1;

  phase_t        phase_r, phase_nxt;
  radix_t        radix_r, radix_nxt;
  logic          in_frac_r, in_frac_nxt;
  logic [IW-1:0] int_acc_r, int_acc_nxt;
  logic [FW-1:0] frac_acc_r, frac_acc_nxt;
  logic [FW-1:0] scale_r, scale_nxt;
  status_t       status_r, status_nxt;

  logic [7:0]      c;
  logic            do_body;
  logic            is_num;
  logic            is_hex;
  logic            is_dot;
  logic [7:0]      num_off;
  logic [7:0]      hex_off;
  logic [3:0]      digit;
  logic            digit_ok;
  logic [IW+3:0]   int_mul;
  logic [IW+3:0]   int_sum;
  logic [FW+3:0]   frac_mul;
  logic [FW+3:0]   frac_sum;
  logic [2*FW-1:0] div10_prod;
  logic [FW-1:0]   scale_div;
  logic [FW-1:0]   scale_dot;

  assign c       = item.char_code;
  assign is_num  = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_hex  = (c >= CH_A_LC) && (c <= CH_F_LC);
  assign is_dot  = (c == CH_DOT);
  assign num_off = c - CH_ZERO;
  assign hex_off = c - CH_A_LC + 8'd10;
  assign digit   = is_num ? num_off[3:0] : hex_off[3:0];

  always_comb begin
    unique case (radix_r)
      RADIX_BIN: digit_ok = (c == CH_ZERO) || (c == CH_ONE);
      RADIX_HEX: digit_ok = is_num || is_hex;
      default:   digit_ok = is_num;
    endcase
  end

  // integer step acc*radix+digit and the scale for the next fraction digit
  assign div10_prod = (2*FW)'(scale_r) * (2*FW)'(DIV10_M);

  always_comb begin
    unique case (radix_r)
      RADIX_BIN: begin
        int_mul   = {3'b000, int_acc_r, 1'b0};
        scale_div = scale_r >> 1;
        scale_dot = SCALE2;
      end
      RADIX_HEX: begin
        int_mul   = {int_acc_r, 4'b0000};
        scale_div = scale_r >> 4;
        scale_dot = SCALE16;
      end
      default: begin
        int_mul   = {1'b0, int_acc_r, 3'b000} + {3'b000, int_acc_r, 1'b0};
        scale_div = FW'(div10_prod[2*FW-1:FW+3]);
        scale_dot = SCALE10;
      end
    endcase
  end

  assign int_sum  = int_mul + (IW+4)'(digit);
  assign frac_mul = (FW+4)'(scale_r) * (FW+4)'(digit);
  assign frac_sum = frac_mul + (FW+4)'(frac_acc_r);

  always_comb begin
    phase_nxt    = phase_r;
    radix_nxt    = radix_r;
    in_frac_nxt  = in_frac_r;
    int_acc_nxt  = int_acc_r;
    frac_acc_nxt = frac_acc_r;
    scale_nxt    = scale_r;
    status_nxt   = status_r;
    do_body      = 1'b0;

    unique case (phase_r)
      PH_START: begin
        if (c == CH_ZERO) begin
          phase_nxt = PH_ZERO;
        end else begin
          phase_nxt = PH_BODY;
          do_body   = 1'b1;
        end
      end
      PH_ZERO: begin
        phase_nxt = PH_BODY;
        if (c == CH_B_LC) begin
          radix_nxt = RADIX_BIN;
        end else if (c == CH_X_LC) begin
          radix_nxt = RADIX_HEX;
        end else begin
          do_body = 1'b1;
        end
      end
      default: do_body = 1'b1;
    endcase

    if (do_body) begin
      if (is_dot) begin
        if (in_frac_r) begin
          status_nxt = ST_INVALID;
        end else begin
          in_frac_nxt = 1'b1;
          scale_nxt   = scale_dot;
        end
      end else if (!digit_ok) begin
        status_nxt = ST_INVALID;
      end else if (in_frac_r) begin
        frac_acc_nxt = (frac_sum[FW+3:FW] != '0) ? FRAC_MAX : frac_sum[FW-1:0];
        scale_nxt    = scale_div;
      end else if (int_sum[IW+3:IW] != '0) begin
        int_acc_nxt = INT_MAX;
        if (status_r != ST_INVALID) begin
          status_nxt = ST_SATURATED;
        end
      end else begin
        int_acc_nxt = int_sum[IW-1:0];
      end
    end
  end

  assign res_valid  = advance && item.is_last;
  assign res_status = status_nxt;
  assign res_value  = (status_nxt == ST_INVALID) ? '0 : {int_acc_nxt, frac_acc_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n || res_valid) begin
      phase_r    <= PH_START;
      radix_r    <= RADIX_DEC;
      in_frac_r  <= 1'b0;
      int_acc_r  <= '0;
      frac_acc_r <= '0;
      scale_r    <= '0;
      status_r   <= ST_OK;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      radix_r    <= radix_nxt;
      in_frac_r  <= in_frac_nxt;
      int_acc_r  <= int_acc_nxt;
      frac_acc_r <= frac_acc_nxt;
      scale_r    <= scale_nxt;
      status_r   <= status_nxt;
    end
  end

endmodule

/* rtl/core/radix_number_literal_parser.sv */
// Number literal parser: takes one ASCII character per item on the in_ stream (tlast marks
// the final character) and returns one result per literal on the out_ stream, an unsigned
// fixed point value with INT_BITS integer and FRAC_BITS fraction bits plus a status (0 ok,
// 1 invalid character, 2 integer part saturated; value reads 0 when invalid). A leading
// "0b" or "0x" picks radix 2 or 16, otherwise decimal; hex digits are lower case only.
// One character is taken every clock cycle while no finished result is stalled: each
// character held in the input register updates the integer accumulator, fraction
// accumulator and fraction scale, and a result is then held in the output register
// until it is taken. in_tready drops only while a finished result is stalled.
`include "radix_number_literal_parser_assert.svh"

module radix_number_literal_parser
  import rnlp_pkg::*;
#(
  parameter int INT_BITS  = DEF_INT_BITS,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,   // char_code
  input  logic                  in_tlast,   // is_last
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [((INT_BITS+FRAC_BITS+2+7)/8)*8-1:0] out_tdata  // value, status, zero pad
);

  localparam int VAL_W  = INT_BITS + FRAC_BITS;
  localparam int DATA_W = ((VAL_W + 2 + 7) / 8) * 8;

  char_item_t         in_item;
  char_item_t         item;
  logic               item_valid;
  logic               advance;
  logic               res_valid;
  logic [VAL_W-1:0]   res_value;
  status_t            res_status;

  logic               out_valid_r;
  logic [VAL_W-1:0]   out_value_r;
  logic [1:0]         out_status_r;

  assign in_item.char_code = in_tdata;
  assign in_item.is_last   = in_tlast;
  assign advance           = item_valid && (!out_valid_r || out_tready);

  rnlp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  rnlp_parse_core #(
    .INT_BITS  (INT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .item       (item),
    .res_valid  (res_valid),
    .res_value  (res_value),
    .res_status (res_status)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_value_r  <= res_value;
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DATA_W'({out_status_r, out_value_r});

  // an invalid literal never carries a value
  `RNLP_ASSERT(a_invalid_zero, clk, rst_n, out_valid_r && (out_status_r == ST_INVALID) |-> (out_value_r == '0), "invalid result with nonzero value")

  // input side stalls only behind a stalled result
  `RNLP_ASSERT(a_stall_cause, clk, rst_n, !in_tready |-> (out_valid_r && !out_tready), "input stalled without a waiting result")

  // a new result follows only a last character
  `RNLP_ASSERT(a_result_after_last, clk, rst_n, $rose(out_valid_r) |-> $past(item_valid && item.is_last), "result without a last character")

endmodule
